>>> src/bpa_pkg.sv
package bpa_pkg;

    localparam int FUNC_W        = 3;
    localparam int PAGE_INDEX_W  = 16;
    localparam int ADDR_W        = 52;
    localparam int COUNT_W       = 17;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 52;

    localparam int PAGE_SHIFT    = 12;
    localparam int BYTE_SHIFT    = 3;
    localparam int PAGE_ROUND    = 4095;

    localparam int DEF_MAX_PAGES = 65536;
    localparam int DEF_WORD_BITS = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_COUNT   = CFG_INDEX_W'(1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_GRANT = 3'd0,
        FUNC_MARK  = 3'd1,
        FUNC_FREE  = 3'd2,
        FUNC_QUERY = 3'd3,
        FUNC_INIT  = 3'd4
    } bpa_func_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_LOCATE,
        S_UPDATE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_RESP
    } bpa_state_t;

    typedef struct packed {
        logic granted;
        logic page_free;
        logic has_addr;
    } bpa_status_t;

endpackage

>>> src/bpa_req_if.sv
interface bpa_req_if import bpa_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic [PAGE_INDEX_W-1:0] page_index;

    modport source (output valid, output func, output page_index, input ready);
    modport sink (input valid, input func, input page_index, output ready);

endinterface

>>> src/bpa_rsp_if.sv
interface bpa_rsp_if import bpa_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic                    granted;
    logic                    page_free;
    logic [ADDR_W-1:0]       page_address;
    logic [PAGE_INDEX_W-1:0] granted_index;

    modport source (output valid, output granted, output page_free, output page_address,
                    output granted_index, input ready);
    modport sink (input valid, input granted, input page_free, input page_address,
                  input granted_index, output ready);

endinterface

>>> src/bpa_cfg_if.sv
interface bpa_cfg_if import bpa_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);

endinterface

>>> src/bpa_ram.sv
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/bpa_word_find.sv
module bpa_word_find #(
    parameter int WORD_BITS = 64,
    localparam int BI_W     = $clog2(WORD_BITS)
) (
    input  logic [WORD_BITS-1:0] cand,
    output logic                 found,
    output logic [WORD_BITS-1:0] onehot,
    output logic [BI_W-1:0]      pos
);

    // Isolate the lowest set bit, then encode its position.
    assign found  = |cand;
    assign onehot = cand & (~cand + WORD_BITS'(1));

    always_comb
    begin
        pos = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (onehot[b])
            begin
                pos = pos | BI_W'(b);
            end
        end
    end

endmodule

>>> src/bpa_core.sv
module bpa_core import bpa_pkg::*; #(
    parameter int MAX_PAGES = DEF_MAX_PAGES,
    parameter int WORD_BITS = DEF_WORD_BITS,
    localparam int PG_W     = $clog2(MAX_PAGES),
    localparam int CNT_W    = $clog2(MAX_PAGES + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic [FUNC_W-1:0]       req_func,
    input  logic [PAGE_INDEX_W-1:0] req_page_index,
    input  logic [CNT_W-1:0]        cnt,
    output logic                    res_valid,
    input  logic                    res_taken,
    output bpa_status_t             res_status,
    output logic [PG_W-1:0]         res_index
);

    localparam int WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BI_W  = $clog2(WORD_BITS);
    localparam int RECIP = (2 ** PG_W) / WORD_BITS;

    bpa_state_t            state_reg, state_next;
    bpa_func_t             func_reg, func_next;
    logic [PG_W-1:0]       idx_reg, idx_next;
    logic [2*PG_W-1:0]     prod_reg, prod_next;
    logic [PG_W-1:0]       q0_reg, q0_next;
    logic [PG_W-1:0]       qw_reg, qw_next;
    logic [WA_W-1:0]       w_reg, w_next;
    logic [PG_W-1:0]       base_reg, base_next;
    logic [BI_W-1:0]       bit_reg, bit_next;
    logic [WA_W-1:0]       hint_w_reg, hint_w_next;
    logic [PG_W-1:0]       hint_base_reg, hint_base_next;
    logic [CNT_W-1:0]      reserve_reg, reserve_next;
    logic                  clr_init_reg, clr_init_next;
    bpa_status_t           res_status_reg, res_status_next;
    logic [PG_W-1:0]       res_index_reg, res_index_next;

    logic                  ram_we;
    logic [WA_W-1:0]       ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [WA_W-1:0]       ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;

    logic [PG_W+15:0]      idx_wide;
    logic [CNT_W+15:0]     pi_ext;
    logic                  idx_ok;
    logic [CNT_W+12:0]     rsv_wide;
    logic [CNT_W-1:0]      rsv_eff;

    logic [PG_W-1:0]       r0;
    logic                  fix;
    logic [PG_W-1:0]       q_fix;
    logic [PG_W-1:0]       r_fix;
    logic [PG_W-1:0]       base_fix;

    logic [CNT_W-1:0]      lim_top;
    logic [CNT_W-1:0]      base_ext;
    logic [CNT_W-1:0]      range_lim;
    logic [WORD_BITS-1:0]  range_mask;
    logic [WORD_BITS-1:0]  cand;
    logic                  found;
    logic [WORD_BITS-1:0]  found_onehot;
    logic [BI_W-1:0]       found_pos;
    logic                  all_ones;
    logic [CNT_W:0]        next_base;
    logic                  scan_more;
    logic                  clear_last;
    logic [WORD_BITS-1:0]  sel_onehot;

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bpa_word_find #(
        .WORD_BITS (WORD_BITS)
    ) u_find (
        .cand   (cand),
        .found  (found),
        .onehot (found_onehot),
        .pos    (found_pos)
    );

    // Request decode and reserve size for initialization.
    always_comb
    begin
        idx_wide = {PG_W'(0), req_page_index};
        pi_ext   = (CNT_W + 16)'(req_page_index);
        idx_ok   = pi_ext < (CNT_W + 16)'(cnt);
        rsv_wide = (((CNT_W + 13)'(cnt) >> BYTE_SHIFT) + (CNT_W + 13)'(PAGE_ROUND))
                   >> PAGE_SHIFT;
        rsv_eff  = (rsv_wide < (CNT_W + 13)'(cnt)) ? rsv_wide[CNT_W-1:0] : cnt;
    end

    // Correction step of the reciprocal division into word and bit.
    always_comb
    begin
        r0       = idx_reg - qw_reg;
        fix      = r0 >= PG_W'(WORD_BITS);
        q_fix    = fix ? (q0_reg + PG_W'(1)) : q0_reg;
        r_fix    = fix ? (r0 - PG_W'(WORD_BITS)) : r0;
        base_fix = fix ? (qw_reg + PG_W'(WORD_BITS)) : qw_reg;
    end

    // Bits of the current word that lie below the active limit.
    always_comb
    begin
        lim_top   = (state_reg == S_CLEAR) ? reserve_reg : cnt;
        base_ext  = CNT_W'(base_reg);
        range_lim = (lim_top > base_ext) ? (lim_top - base_ext) : '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            range_mask[b] = CNT_W'(b) < range_lim;
        end
        cand       = ~ram_rdata & range_mask;
        all_ones   = &ram_rdata;
        next_base  = (CNT_W + 1)'(base_reg) + (CNT_W + 1)'(WORD_BITS);
        scan_more  = all_ones && (next_base < (CNT_W + 1)'(cnt));
        clear_last = w_reg == WA_W'(WORDS - 1);
        sel_onehot = WORD_BITS'(1) << bit_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = clr_init_reg ? S_RESP : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    case (bpa_func_t'(req_func))
                        FUNC_GRANT: state_next = S_SCAN_RD;
                        FUNC_MARK, FUNC_FREE, FUNC_QUERY:
                            state_next = idx_ok ? S_MUL : S_RESP;
                        FUNC_INIT:  state_next = S_CLEAR;
                        default:    state_next = S_RESP;
                    endcase
                end
            end
            S_MUL:     state_next = S_SCALE;
            S_SCALE:   state_next = S_LOCATE;
            S_LOCATE:  state_next = S_UPDATE;
            S_UPDATE:  state_next = S_RESP;
            S_SCAN_RD: state_next = S_SCAN_EV;
            S_SCAN_EV: state_next = (!found && scan_more) ? S_SCAN_RD : S_RESP;
            S_RESP:
            begin
                if (res_taken)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        func_next       = func_reg;
        idx_next        = idx_reg;
        prod_next       = prod_reg;
        q0_next         = q0_reg;
        qw_next         = qw_reg;
        w_next          = w_reg;
        base_next       = base_reg;
        bit_next        = bit_reg;
        hint_w_next     = hint_w_reg;
        hint_base_next  = hint_base_reg;
        reserve_next    = reserve_reg;
        clr_init_next   = clr_init_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        ram_we          = 1'b0;
        ram_waddr       = w_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = w_reg;
        req_ready       = 1'b0;
        res_valid       = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = range_mask;
                if (clear_last)
                begin
                    clr_init_next   = 1'b0;
                    res_status_next = '{granted: 1'b1, page_free: 1'b0, has_addr: 1'b0};
                    res_index_next  = '0;
                end
                else
                begin
                    w_next    = w_reg + WA_W'(1);
                    base_next = base_reg + PG_W'(WORD_BITS);
                end
            end
            S_IDLE:
            begin
                req_ready       = 1'b1;
                func_next       = bpa_func_t'(req_func);
                idx_next        = idx_wide[PG_W-1:0];
                res_status_next = '0;
                res_index_next  = '0;
                if (req_valid)
                begin
                    case (bpa_func_t'(req_func))
                        FUNC_GRANT:
                        begin
                            w_next    = hint_w_reg;
                            base_next = hint_base_reg;
                        end
                        FUNC_INIT:
                        begin
                            reserve_next   = rsv_eff;
                            clr_init_next  = 1'b1;
                            w_next         = '0;
                            base_next      = '0;
                            hint_w_next    = '0;
                            hint_base_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                prod_next = (2 * PG_W)'(idx_reg) * (2 * PG_W)'(RECIP);
            end
            S_SCALE:
            begin
                q0_next = prod_reg[2*PG_W-1:PG_W];
                qw_next = PG_W'(prod_reg[2*PG_W-1:PG_W] * WORD_BITS);
            end
            S_LOCATE:
            begin
                ram_raddr = q_fix[WA_W-1:0];
                w_next    = q_fix[WA_W-1:0];
                bit_next  = r_fix[BI_W-1:0];
                base_next = base_fix;
            end
            S_UPDATE:
            begin
                case (func_reg)
                    FUNC_MARK:
                    begin
                        ram_we          = 1'b1;
                        ram_wdata       = ram_rdata | sel_onehot;
                        res_status_next = '{granted: 1'b1, page_free: 1'b0, has_addr: 1'b1};
                        res_index_next  = idx_reg;
                    end
                    FUNC_FREE:
                    begin
                        ram_we          = 1'b1;
                        ram_wdata       = ram_rdata & ~sel_onehot;
                        res_status_next = '{granted: 1'b1, page_free: 1'b0, has_addr: 1'b0};
                        if (w_reg < hint_w_reg)
                        begin
                            hint_w_next    = w_reg;
                            hint_base_next = base_reg;
                        end
                    end
                    default:
                    begin
                        res_status_next = '{granted: 1'b1,
                                            page_free: ~|(ram_rdata & sel_onehot),
                                            has_addr: 1'b0};
                    end
                endcase
            end
            S_SCAN_EV:
            begin
                if (found)
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = ram_rdata | found_onehot;
                    res_status_next = '{granted: 1'b1, page_free: 1'b0, has_addr: 1'b1};
                    res_index_next  = base_reg + PG_W'(found_pos);
                    hint_w_next     = w_reg;
                    hint_base_next  = base_reg;
                end
                else if (scan_more)
                begin
                    w_next    = w_reg + WA_W'(1);
                    base_next = base_reg + PG_W'(WORD_BITS);
                end
                else
                begin
                    res_status_next = '0;
                    hint_w_next     = w_reg;
                    hint_base_next  = base_reg;
                end
            end
            S_RESP:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            w_reg         <= '0;
            base_reg      <= '0;
            hint_w_reg    <= '0;
            hint_base_reg <= '0;
            reserve_reg   <= '0;
            clr_init_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            w_reg         <= w_next;
            base_reg      <= base_next;
            hint_w_reg    <= hint_w_next;
            hint_base_reg <= hint_base_next;
            reserve_reg   <= reserve_next;
            clr_init_reg  <= clr_init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        idx_reg        <= idx_next;
        prod_reg       <= prod_next;
        q0_reg         <= q0_next;
        qw_reg         <= qw_next;
        bit_reg        <= bit_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
    end

    assign res_status = res_status_reg;
    assign res_index  = res_index_reg;

endmodule

>>> src/bitmap_page_allocator.sv
// Bitmap page allocator with first-fit grant. Requests arrive on req, one word each,
// carrying a function code and a page index; every request returns exactly one word on
// rsp. Registers are written through cfg (base address, page count); cfg is always ready.
// They must be written only while no request is in flight; the block does not enforce it.
// The used bitmap lives in a single memory of WORD_BITS-wide words. After reset the
// block sweeps the memory to zero, one word per cycle, and holds req ready low until
// the sweep ends. Initialize runs the same sweep, but sets the bits of the pages below
// the reserve size derived from the page count, and then answers.
// Mark, free and query pass through S_MUL, S_SCALE, S_LOCATE and S_UPDATE to S_RESP:
// the reciprocal division of the page index and the read-modify-write of its bitmap word.
// An index not below the page count goes straight to S_RESP. A grant starts at a remembered
// word below which every word is full and reads one word at a time, passing full words.
// The core is ready for the next request in the cycle after it hands its result to the
// output register. A stalled receiver holds the response in that register; the core
// can still accept and finish one more request, then waits until the register frees.
module bitmap_page_allocator import bpa_pkg::*; #(
    parameter int MAX_PAGES = DEF_MAX_PAGES,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    bpa_req_if.sink    req,
    bpa_rsp_if.source  rsp,
    bpa_cfg_if.sink    cfg
);

    localparam int PG_W  = $clog2(MAX_PAGES);
    localparam int CNT_W = $clog2(MAX_PAGES + 1);

    logic [ADDR_W-1:0]       base_address_reg, base_address_next;
    logic [COUNT_W-1:0]      page_count_reg, page_count_next;
    logic [CNT_W+COUNT_W-1:0] pc_ext;
    logic [CNT_W-1:0]        cnt;

    logic                    res_valid;
    logic                    res_taken;
    bpa_status_t             res_status;
    logic [PG_W-1:0]         res_index;
    logic [PG_W+15:0]        res_index_wide;

    logic                    out_valid_reg, out_valid_next;
    logic                    granted_reg, granted_next;
    logic                    page_free_reg, page_free_next;
    logic [ADDR_W-1:0]       page_address_reg, page_address_next;
    logic [PAGE_INDEX_W-1:0] granted_index_reg, granted_index_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        base_address_next = base_address_reg;
        page_count_next   = page_count_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_BASE_ADDRESS: base_address_next = cfg.data[ADDR_W-1:0];
                CFG_PAGE_COUNT:   page_count_next   = cfg.data[COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
        pc_ext = (CNT_W + COUNT_W)'(page_count_reg);
        cnt    = (pc_ext > (CNT_W + COUNT_W)'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                           : pc_ext[CNT_W-1:0];
    end

    bpa_core #(
        .MAX_PAGES (MAX_PAGES),
        .WORD_BITS (WORD_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req.valid),
        .req_ready      (req.ready),
        .req_func       (req.func),
        .req_page_index (req.page_index),
        .cnt            (cnt),
        .res_valid      (res_valid),
        .res_taken      (res_taken),
        .res_status     (res_status),
        .res_index      (res_index)
    );

    always_comb
    begin
        res_taken          = res_valid && (!out_valid_reg || rsp.ready);
        res_index_wide     = {16'(0), res_index};
        out_valid_next     = out_valid_reg;
        granted_next       = granted_reg;
        page_free_next     = page_free_reg;
        page_address_next  = page_address_reg;
        granted_index_next = granted_index_reg;
        if (res_taken)
        begin
            out_valid_next     = 1'b1;
            granted_next       = res_status.granted;
            page_free_next     = res_status.page_free;
            page_address_next  = res_status.has_addr
                               ? (base_address_reg + (ADDR_W'(res_index) << PAGE_SHIFT))
                               : '0;
            granted_index_next = res_status.has_addr ? res_index_wide[PAGE_INDEX_W-1:0]
                                                     : '0;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= '0;
            page_count_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            base_address_reg <= base_address_next;
            page_count_reg   <= page_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        granted_reg       <= granted_next;
        page_free_reg     <= page_free_next;
        page_address_reg  <= page_address_next;
        granted_index_reg <= granted_index_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.granted       = granted_reg;
    assign rsp.page_free     = page_free_reg;
    assign rsp.page_address  = page_address_reg;
    assign rsp.granted_index = granted_index_reg;

endmodule
